>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL. Empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked only while out of reset.
`define LM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lmext assertion failed");
// Checked on every edge, reset included.
`define LM_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lmext assertion failed");
`else
`define LM_ASSERT(lbl, clk, rst_n, prop)
`define LM_ASSERT_NR(lbl, clk, prop)
`endif
`endif

>>> rtl/lmext_pkg.sv
package lmext_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int AXIS_W          = 21;
    localparam int OPND_W          = 64;
    localparam int ACC_W           = 128;
    localparam int MUL_CHUNK       = 16;
    localparam int MUL_STEPS       = OPND_W / MUL_CHUNK;
    localparam int CHUNK_CW        = $clog2(MUL_STEPS);
    localparam int CHUNK_LOG       = $clog2(MUL_CHUNK);
    localparam int N_MSTEP         = 27;
    localparam int STEP_W          = $clog2(N_MSTEP);
    localparam int UV_W            = 48;
    localparam int UV_FRAC         = 16;
    localparam int NUM_SHIFT       = 4;
    localparam int BASE_SHIFT      = 12;
    localparam int BIAS            = 7;
    localparam int SCALE_NUM       = 64;
    localparam int SCALE_DEN       = 16;
    localparam int SCALE_SHIFT     = $clog2(SCALE_NUM / SCALE_DEN);
    localparam int EXT_W           = UV_W + SCALE_SHIFT + 2;
    localparam int TEX_W           = 16;
    localparam int SIZE_W          = 10;
    localparam int SIZE_MAX        = 1023;
    localparam int AXIS_PACK_W     = 3 * AXIS_W;
    localparam int CFG_W           = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int DIV_CNT_W       = $clog2(ACC_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_U_AXIS  = 2'd0,
        CFG_V_AXIS  = 2'd1,
        CFG_NORMAL  = 2'd2,
        CFG_UV_BASE = 2'd3
    } t_cfg_reg;

    typedef enum logic [4:0] {
        OP_U0, OP_U1, OP_U2, OP_V0, OP_V1, OP_V2, OP_N0, OP_N1, OP_N2,
        OP_W0, OP_W1, OP_W2, OP_X0, OP_X1, OP_X2, OP_R0, OP_R1, OP_R2,
        OP_UB, OP_VB
    } t_opnd;

    typedef enum logic [2:0] {
        INIT_KEEP, INIT_ZERO, INIT_DX, INIT_DY, INIT_DZ
    } t_init;

    typedef enum logic [3:0] {
        DST_NONE, DST_W0, DST_W1, DST_W2, DST_X0, DST_X1, DST_X2,
        DST_D, DST_R0, DST_R1, DST_R2, DST_NU, DST_NV
    } t_dst;

    typedef struct packed {
        t_opnd a;
        t_opnd b;
        logic  sub;
        t_init init;
        t_dst  dst;
    } t_mstep;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_CHKD, S_DIVU, S_DIVV, S_UPD, S_EMIT
    } t_state;

    typedef struct packed {
        logic                load_vtx;
        logic                mul_en;
        t_mstep              step;
        logic [CHUNK_CW-1:0] chunk;
        logic                div_start;
        logic                div_v;
        logic                zero_uv;
        logic                update;
        logic                emit;
    } t_cmd;

    typedef struct packed {
        logic d_zero;
        logic div_done;
        logic last;
        logic out_free;
    } t_stat;

    function automatic t_mstep ms(t_opnd a, t_opnd b, logic sub, t_init i, t_dst d);
        t_mstep s;
        s.a    = a;
        s.b    = b;
        s.sub  = sub;
        s.init = i;
        s.dst  = d;
        return s;
    endfunction

    // Multiply-accumulate program: cross products W = VxN and X = NxU,
    // determinant D = U.W, right-hand side R, then the two numerators.
    function automatic t_mstep mstep(logic [STEP_W-1:0] idx);
        t_mstep s;
        case (idx)
            5'd0:  s = ms(OP_V1, OP_N2, 1'b0, INIT_ZERO, DST_NONE);
            5'd1:  s = ms(OP_V2, OP_N1, 1'b1, INIT_KEEP, DST_W0);
            5'd2:  s = ms(OP_V2, OP_N0, 1'b0, INIT_ZERO, DST_NONE);
            5'd3:  s = ms(OP_V0, OP_N2, 1'b1, INIT_KEEP, DST_W1);
            5'd4:  s = ms(OP_V0, OP_N1, 1'b0, INIT_ZERO, DST_NONE);
            5'd5:  s = ms(OP_V1, OP_N0, 1'b1, INIT_KEEP, DST_W2);
            5'd6:  s = ms(OP_N1, OP_U2, 1'b0, INIT_ZERO, DST_NONE);
            5'd7:  s = ms(OP_N2, OP_U1, 1'b1, INIT_KEEP, DST_X0);
            5'd8:  s = ms(OP_N2, OP_U0, 1'b0, INIT_ZERO, DST_NONE);
            5'd9:  s = ms(OP_N0, OP_U2, 1'b1, INIT_KEEP, DST_X1);
            5'd10: s = ms(OP_N0, OP_U1, 1'b0, INIT_ZERO, DST_NONE);
            5'd11: s = ms(OP_N1, OP_U0, 1'b1, INIT_KEEP, DST_X2);
            5'd12: s = ms(OP_U0, OP_W0, 1'b0, INIT_ZERO, DST_NONE);
            5'd13: s = ms(OP_U1, OP_W1, 1'b0, INIT_KEEP, DST_NONE);
            5'd14: s = ms(OP_U2, OP_W2, 1'b0, INIT_KEEP, DST_D);
            5'd15: s = ms(OP_U0, OP_UB, 1'b0, INIT_DX,   DST_NONE);
            5'd16: s = ms(OP_V0, OP_VB, 1'b0, INIT_KEEP, DST_R0);
            5'd17: s = ms(OP_U1, OP_UB, 1'b0, INIT_DY,   DST_NONE);
            5'd18: s = ms(OP_V1, OP_VB, 1'b0, INIT_KEEP, DST_R1);
            5'd19: s = ms(OP_U2, OP_UB, 1'b0, INIT_DZ,   DST_NONE);
            5'd20: s = ms(OP_V2, OP_VB, 1'b0, INIT_KEEP, DST_R2);
            5'd21: s = ms(OP_R0, OP_W0, 1'b0, INIT_ZERO, DST_NONE);
            5'd22: s = ms(OP_R1, OP_W1, 1'b0, INIT_KEEP, DST_NONE);
            5'd23: s = ms(OP_R2, OP_W2, 1'b0, INIT_KEEP, DST_NU);
            5'd24: s = ms(OP_R0, OP_X0, 1'b0, INIT_ZERO, DST_NONE);
            5'd25: s = ms(OP_R1, OP_X1, 1'b0, INIT_KEEP, DST_NONE);
            5'd26: s = ms(OP_R2, OP_X2, 1'b0, INIT_KEEP, DST_NV);
            default: s = ms(OP_U0, OP_U0, 1'b0, INIT_KEEP, DST_NONE);
        endcase
        return s;
    endfunction

    function automatic logic signed [OPND_W-1:0] sext_axis(logic [AXIS_W-1:0] x);
        return {{(OPND_W-AXIS_W){x[AXIS_W-1]}}, x};
    endfunction

endpackage

>>> rtl/lmext_if.sv
interface lmext_vtx_if #(
    parameter int COORD_WIDTH = lmext_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic signed [COORD_WIDTH-1:0] vertex_z;
    logic                          last_vertex;

    modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface lmext_res_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lmext_pkg::TEX_W-1:0]    base_u_texel;
    logic signed [lmext_pkg::TEX_W-1:0]    base_v_texel;
    logic        [lmext_pkg::SIZE_W-1:0]   map_width;
    logic        [lmext_pkg::SIZE_W-1:0]   map_height;
    logic                                  size_clamped;
    logic                                  degenerate_axes;

    modport source (output valid, base_u_texel, base_v_texel, map_width, map_height,
                    size_clamped, degenerate_axes, input ready);
    modport sink   (input valid, base_u_texel, base_v_texel, map_width, map_height,
                    size_clamped, degenerate_axes, output ready);
endinterface

>>> rtl/lmext_div.sv
module lmext_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [lmext_pkg::ACC_W-1:0]  i_num,
    input  logic signed [lmext_pkg::OPND_W-1:0] i_den,
    output logic                                o_done,
    output logic signed [lmext_pkg::UV_W-1:0]   o_quo
);
    import lmext_pkg::*;

    // Restoring divider, one quotient bit per cycle, on magnitudes.
    logic                  r_busy, r_done, r_neg;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [ACC_W-1:0]      r_num, r_q;
    logic [OPND_W-1:0]     r_dm, r_rem;
    logic [ACC_W-1:0]      num_mag;
    logic [OPND_W:0]       rem_sh;
    logic                  ge;
    logic                  ovf;
    logic [UV_W-1:0]       mag;

    assign num_mag = i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
    assign rem_sh  = {r_rem, r_num[ACC_W-1]};
    assign ge      = rem_sh >= {1'b0, r_dm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(ACC_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[ACC_W-1] ^ i_den[OPND_W-1];
            r_num <= num_mag << NUM_SHIFT;
            r_dm  <= i_den[OPND_W-1] ? OPND_W'(-i_den) : OPND_W'(i_den);
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= ge ? OPND_W'(rem_sh - {1'b0, r_dm}) : OPND_W'(rem_sh);
            r_q   <= {r_q[ACC_W-2:0], ge};
        end
    end

    // Saturate to signed 48 bits, asymmetric limit for negative results.
    always_comb begin
        if (r_neg) begin
            ovf = (|r_q[ACC_W-1:UV_W]) || (r_q[UV_W-1] && (|r_q[UV_W-2:0]));
            mag = ovf ? {1'b1, {(UV_W-1){1'b0}}} : r_q[UV_W-1:0];
            o_quo = signed'(-mag);
        end else begin
            ovf = |r_q[ACC_W-1:UV_W-1];
            mag = ovf ? {1'b0, {(UV_W-1){1'b1}}} : r_q[UV_W-1:0];
            o_quo = signed'(mag);
        end
    end

    assign o_done = r_done;

endmodule

>>> rtl/lmext_dp.sv
module lmext_dp #(
    parameter int COORD_WIDTH = lmext_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lmext_pkg::t_cmd                      i_cmd,
    output lmext_pkg::t_stat                     o_stat,
    input  logic                                 i_cfg_we,
    input  logic [lmext_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lmext_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic signed [COORD_WIDTH-1:0]        i_vx,
    input  logic signed [COORD_WIDTH-1:0]        i_vy,
    input  logic signed [COORD_WIDTH-1:0]        i_vz,
    input  logic                                 i_last,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [lmext_pkg::TEX_W-1:0]   o_base_u,
    output logic signed [lmext_pkg::TEX_W-1:0]   o_base_v,
    output logic [lmext_pkg::SIZE_W-1:0]         o_width,
    output logic [lmext_pkg::SIZE_W-1:0]         o_height,
    output logic                                 o_clamped,
    output logic                                 o_degen
);
    import lmext_pkg::*;

    localparam int DIFF_W = COORD_WIDTH + 1;

    logic [AXIS_PACK_W-1:0]         r_cfg_u, r_cfg_v, r_cfg_n;
    logic [CFG_W-1:0]               r_cfg_base;
    logic signed [COORD_WIDTH-1:0]  r_px, r_py, r_pz, r_ox, r_oy, r_oz;
    logic                           r_have, r_first, r_last, r_degen, r_div_v;
    logic signed [OPND_W-1:0]       r_w0, r_w1, r_w2, r_x0, r_x1, r_x2;
    logic signed [OPND_W-1:0]       r_r0, r_r1, r_r2, r_d;
    logic signed [ACC_W-1:0]        r_acc, r_nu, r_nv;
    logic signed [UV_W-1:0]         r_uq, r_vq, r_ulo, r_uhi, r_vlo, r_vhi;
    logic                           r_out_valid;

    logic signed [DIFF_W-1:0]       diff_x, diff_y, diff_z;
    logic signed [OPND_W-1:0]       opa, opb;
    logic [MUL_CHUNK-1:0]           chunk_bits;
    logic signed [MUL_CHUNK:0]      chunk_s;
    logic signed [OPND_W+MUL_CHUNK:0] prod;
    logic signed [ACC_W-1:0]        pp, acc_base, n_acc;
    logic                           div_done;
    logic signed [UV_W-1:0]         div_quo;
    logic                           out_free;
    logic [SIZE_W:0]                size_u, size_v;

    function automatic logic signed [OPND_W-1:0] opnd(t_opnd s);
        logic signed [OPND_W-1:0] r;
        case (s)
            OP_U0: r = sext_axis(r_cfg_u[AXIS_W-1:0]);
            OP_U1: r = sext_axis(r_cfg_u[2*AXIS_W-1:AXIS_W]);
            OP_U2: r = sext_axis(r_cfg_u[3*AXIS_W-1:2*AXIS_W]);
            OP_V0: r = sext_axis(r_cfg_v[AXIS_W-1:0]);
            OP_V1: r = sext_axis(r_cfg_v[2*AXIS_W-1:AXIS_W]);
            OP_V2: r = sext_axis(r_cfg_v[3*AXIS_W-1:2*AXIS_W]);
            OP_N0: r = sext_axis(r_cfg_n[AXIS_W-1:0]);
            OP_N1: r = sext_axis(r_cfg_n[2*AXIS_W-1:AXIS_W]);
            OP_N2: r = sext_axis(r_cfg_n[3*AXIS_W-1:2*AXIS_W]);
            OP_W0: r = r_w0;
            OP_W1: r = r_w1;
            OP_W2: r = r_w2;
            OP_X0: r = r_x0;
            OP_X1: r = r_x1;
            OP_X2: r = r_x2;
            OP_R0: r = r_r0;
            OP_R1: r = r_r1;
            OP_R2: r = r_r2;
            OP_UB: r = OPND_W'(signed'(r_cfg_base[CFG_W/2-1:0]));
            OP_VB: r = OPND_W'(signed'(r_cfg_base[CFG_W-1:CFG_W/2]));
            default: r = '0;
        endcase
        return r;
    endfunction

    // Floored low edge in texels, before saturation.
    function automatic logic signed [EXT_W-1:0] lo_edge(logic signed [UV_W-1:0] x);
        logic signed [EXT_W-1:0] t;
        t = (EXT_W'(x) <<< SCALE_SHIFT) + EXT_W'(BIAS);
        return t >>> UV_FRAC;
    endfunction

    function automatic logic signed [EXT_W-1:0] hi_edge(logic signed [UV_W-1:0] x);
        logic signed [EXT_W-1:0] t;
        t = (EXT_W'(x) <<< SCALE_SHIFT) - EXT_W'(BIAS) + EXT_W'((1 << UV_FRAC) - 1);
        return t >>> UV_FRAC;
    endfunction

    // {clamped, size}
    function automatic logic [SIZE_W:0] size_of(logic signed [UV_W-1:0] lo,
                                                logic signed [UV_W-1:0] hi);
        logic signed [EXT_W-1:0] w;
        logic [SIZE_W:0] r;
        w = hi_edge(hi) - lo_edge(lo) + EXT_W'(1);
        if (w <= 0)
            r = {1'b1, SIZE_W'(1)};
        else if (w > EXT_W'(SIZE_MAX))
            r = {1'b0, SIZE_W'(SIZE_MAX)};
        else
            r = {1'b0, w[SIZE_W-1:0]};
        return r;
    endfunction

    function automatic logic signed [TEX_W-1:0] base_of(logic signed [UV_W-1:0] lo);
        logic signed [EXT_W-1:0] f;
        logic signed [TEX_W-1:0] r;
        f = lo_edge(lo);
        if (f < -EXT_W'(1 << (TEX_W-1)))
            r = {1'b1, {(TEX_W-1){1'b0}}};
        else if (f > EXT_W'((1 << (TEX_W-1)) - 1))
            r = {1'b0, {(TEX_W-1){1'b1}}};
        else
            r = f[TEX_W-1:0];
        return r;
    endfunction

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_u    <= '0;
            r_cfg_v    <= '0;
            r_cfg_n    <= '0;
            r_cfg_base <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_U_AXIS:  r_cfg_u    <= i_cfg_wdata[AXIS_PACK_W-1:0];
                CFG_V_AXIS:  r_cfg_v    <= i_cfg_wdata[AXIS_PACK_W-1:0];
                CFG_NORMAL:  r_cfg_n    <= i_cfg_wdata[AXIS_PACK_W-1:0];
                CFG_UV_BASE: r_cfg_base <= i_cfg_wdata;
                default:     r_cfg_base <= r_cfg_base;
            endcase
        end
    end

    // Shared multiplier: 64 x 16 per cycle, four passes per product
    assign diff_x     = DIFF_W'(r_px) - DIFF_W'(r_ox);
    assign diff_y     = DIFF_W'(r_py) - DIFF_W'(r_oy);
    assign diff_z     = DIFF_W'(r_pz) - DIFF_W'(r_oz);
    assign opa        = opnd(i_cmd.step.a);
    assign opb        = opnd(i_cmd.step.b);
    assign chunk_bits = opb[{i_cmd.chunk, {CHUNK_LOG{1'b0}}} +: MUL_CHUNK];
    assign chunk_s    = {(i_cmd.chunk == CHUNK_CW'(MUL_STEPS-1)) ? chunk_bits[MUL_CHUNK-1]
                                                                 : 1'b0, chunk_bits};
    assign prod       = opa * chunk_s;
    assign pp         = ACC_W'(prod) <<< {i_cmd.chunk, {CHUNK_LOG{1'b0}}};

    always_comb begin
        acc_base = r_acc;
        if (i_cmd.chunk == '0) begin
            case (i_cmd.step.init)
                INIT_KEEP: acc_base = r_acc;
                INIT_ZERO: acc_base = '0;
                INIT_DX:   acc_base = ACC_W'(diff_x) <<< BASE_SHIFT;
                INIT_DY:   acc_base = ACC_W'(diff_y) <<< BASE_SHIFT;
                INIT_DZ:   acc_base = ACC_W'(diff_z) <<< BASE_SHIFT;
                default:   acc_base = r_acc;
            endcase
        end
        n_acc = i_cmd.step.sub ? acc_base - pp : acc_base + pp;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_acc <= n_acc;
            if (i_cmd.chunk == CHUNK_CW'(MUL_STEPS-1)) begin
                case (i_cmd.step.dst)
                    DST_W0: r_w0 <= n_acc[OPND_W-1:0];
                    DST_W1: r_w1 <= n_acc[OPND_W-1:0];
                    DST_W2: r_w2 <= n_acc[OPND_W-1:0];
                    DST_X0: r_x0 <= n_acc[OPND_W-1:0];
                    DST_X1: r_x1 <= n_acc[OPND_W-1:0];
                    DST_X2: r_x2 <= n_acc[OPND_W-1:0];
                    DST_D:  r_d  <= n_acc[OPND_W-1:0];
                    DST_R0: r_r0 <= n_acc[OPND_W-1:0];
                    DST_R1: r_r1 <= n_acc[OPND_W-1:0];
                    DST_R2: r_r2 <= n_acc[OPND_W-1:0];
                    DST_NU: r_nu <= n_acc;
                    DST_NV: r_nv <= n_acc;
                    default: ;
                endcase
            end
        end
    end

    lmext_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (i_cmd.div_v ? r_nv : r_nu),
        .i_den   (r_d),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Vertex, first/last flags and quotients
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vtx) begin
            r_px    <= i_vx;
            r_py    <= i_vy;
            r_pz    <= i_vz;
            r_first <= !r_have;
            r_last  <= i_last;
        end
        if (i_cmd.div_start)
            r_div_v <= i_cmd.div_v;
        if (div_done) begin
            if (r_div_v)
                r_vq <= div_quo;
            else
                r_uq <= div_quo;
        end
        if (i_cmd.zero_uv) begin
            r_uq <= '0;
            r_vq <= '0;
        end
    end

    // Polygon state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_degen <= 1'b0;
            r_ox    <= '0;
            r_oy    <= '0;
            r_oz    <= '0;
            r_ulo   <= '0;
            r_uhi   <= '0;
            r_vlo   <= '0;
            r_vhi   <= '0;
        end else if (i_cmd.emit) begin
            r_have  <= 1'b0;
            r_degen <= 1'b0;
            r_ox    <= '0;
            r_oy    <= '0;
            r_oz    <= '0;
            r_ulo   <= '0;
            r_uhi   <= '0;
            r_vlo   <= '0;
            r_vhi   <= '0;
        end else begin
            if (i_cmd.load_vtx && !r_have) begin
                r_have <= 1'b1;
                r_ox   <= i_vx;
                r_oy   <= i_vy;
                r_oz   <= i_vz;
            end
            if (i_cmd.zero_uv)
                r_degen <= 1'b1;
            if (i_cmd.update) begin
                if (r_first) begin
                    r_ulo <= r_uq;
                    r_uhi <= r_uq;
                    r_vlo <= r_vq;
                    r_vhi <= r_vq;
                end else begin
                    if (r_uq < r_ulo) r_ulo <= r_uq;
                    if (r_uq > r_uhi) r_uhi <= r_uq;
                    if (r_vq < r_vlo) r_vlo <= r_vq;
                    if (r_vq > r_vhi) r_vhi <= r_vq;
                end
            end
        end
    end

    // Result register
    assign out_free = !r_out_valid || i_out_ready;
    assign size_u   = size_of(r_ulo, r_uhi);
    assign size_v   = size_of(r_vlo, r_vhi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_base_u  <= base_of(r_ulo);
            o_base_v  <= base_of(r_vlo);
            o_width   <= size_u[SIZE_W-1:0];
            o_height  <= size_v[SIZE_W-1:0];
            o_clamped <= size_u[SIZE_W] | size_v[SIZE_W];
            o_degen   <= r_degen;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.d_zero   = (r_d == '0);
    assign o_stat.div_done = div_done;
    assign o_stat.last     = r_last;
    assign o_stat.out_free = out_free;

endmodule

>>> rtl/lmext_ctrl.sv
`include "assert_macros.svh"

module lmext_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lmext_pkg::t_stat i_stat,
    output lmext_pkg::t_cmd  o_cmd
);
    import lmext_pkg::*;

    t_state                r_state, n_state;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [CHUNK_CW-1:0]   r_chunk, n_chunk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_chunk <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_chunk <= n_chunk;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_chunk    = r_chunk;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_vtx = 1'b1;
                    n_step         = '0;
                    n_chunk        = '0;
                    n_state        = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.step   = mstep(r_step);
                o_cmd.chunk  = r_chunk;
                n_chunk      = r_chunk + 1'b1;
                if (r_chunk == CHUNK_CW'(MUL_STEPS-1)) begin
                    if (r_step == STEP_W'(N_MSTEP-1))
                        n_state = S_CHKD;
                    else
                        n_step = r_step + 1'b1;
                end
            end
            S_CHKD: begin
                if (i_stat.d_zero) begin
                    o_cmd.zero_uv = 1'b1;
                    n_state       = S_UPD;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVU;
                end
            end
            S_DIVU: begin
                if (i_stat.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_v     = 1'b1;
                    n_state         = S_DIVV;
                end
            end
            S_DIVV: begin
                if (i_stat.div_done)
                    n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = i_stat.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `LM_ASSERT_NR(a_rst_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE))
    `LM_ASSERT(a_emit_free, i_clk, i_rst_n, o_cmd.emit |-> i_stat.out_free)
    `LM_ASSERT(a_accept_mul, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == S_MUL))
    `LM_ASSERT(a_div_nonzero, i_clk, i_rst_n, o_cmd.div_start |-> !i_stat.d_zero)

endmodule

>>> rtl/lightmap_extent_from_polygon_core.sv
// Lightmap extent from a polygon. Vertices come in one word each (signed
// fixed point, 16 fraction bits); the first vertex of a polygon is its origin
// and the word flagged last_vertex closes it and yields one result word:
// base texel u/v, lightmap width/height (1..1023, saturating; size_clamped
// when an extent came out non-positive) and degenerate_axes when the
// U/V/normal determinant was zero. Configure the axes and base offsets only
// while idle. Each vertex runs 27 products on a shared 64x16 multiplier,
// then two 128-step bit-serial divisions for u and v (both skipped when
// the determinant is zero). A new vertex is taken while the previous
// result still waits on the output port.
module lightmap_extent_from_polygon_core #(
    parameter int COORD_WIDTH = lmext_pkg::COORD_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lmext_vtx_if.sink                        i_vtx,
    lmext_res_if.source                      o_res,
    input  logic                             i_cfg_we,
    input  logic [lmext_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lmext_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import lmext_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // Sequencer: multiply program, divisions, extent update, result hand-off
    lmext_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_vtx.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Arithmetic, polygon state, config registers and the result register
    lmext_dp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_vx        (i_vtx.vertex_x),
        .i_vy        (i_vtx.vertex_y),
        .i_vz        (i_vtx.vertex_z),
        .i_last      (i_vtx.last_vertex),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_base_u    (o_res.base_u_texel),
        .o_base_v    (o_res.base_v_texel),
        .o_width     (o_res.map_width),
        .o_height    (o_res.map_height),
        .o_clamped   (o_res.size_clamped),
        .o_degen     (o_res.degenerate_axes)
    );

    assign i_vtx.ready = in_ready;

endmodule
